// ===== rtl/cip_pkg.sv =====
// ----------------------------------------------------------------------------
// Checked integer power package
// Shared widths, microcode step numbers, control word type and the
// microcode program of the square-and-multiply sequencer.
// ----------------------------------------------------------------------------
package cip_pkg;

   // Widths of the stream fields.
   localparam int VALUE_W       = 64;
   localparam int REQ_DATA_W    = 2 * VALUE_W;
   localparam int REQ_USER_W    = 2;
   localparam int RSP_DATA_W    = VALUE_W;
   localparam int RSP_USER_W    = 2;

   // Default operand width in bytes.
   localparam int VALUE_BYTES_DEF = 8;

   // The multiplier forms four half-width partial products per multiply.
   localparam int NUM_PP = 4;
   localparam int MC_W   = 3;
   localparam logic [MC_W-1:0] MC_DONE = MC_W'(NUM_PP);

   // Microcode step numbers.
   typedef logic [3:0] upc_type;
   localparam upc_type S_IDLE   = 4'd0;
   localparam upc_type S_PREP   = 4'd1;
   localparam upc_type S_ZCHK   = 4'd2;
   localparam upc_type S_TEST   = 4'd3;
   localparam upc_type S_CHKBAD = 4'd4;
   localparam upc_type S_MULA   = 4'd5;
   localparam upc_type S_WRA    = 4'd6;
   localparam upc_type S_SQ     = 4'd7;
   localparam upc_type S_SKIPSQ = 4'd8;
   localparam upc_type S_MULS   = 4'd9;
   localparam upc_type S_WRS    = 4'd10;
   localparam upc_type S_FIN    = 4'd11;
   localparam upc_type S_RET    = 4'd12;

   // Datapath actions.
   typedef enum logic [3:0] {
      A_NONE,
      A_LOAD,
      A_PREP,
      A_SETFAIL,
      A_MUL_ACC,
      A_MUL_SQ,
      A_WRACC,
      A_SHIFT,
      A_WRSQ,
      A_FINISH
   } action_type;

   // Jump conditions; a true condition jumps to the target, else fall through.
   typedef enum logic [3:0] {
      C_ALWAYS,
      C_NO_START,
      C_EXP_NEG,
      C_EXP_ZERO,
      C_BIT_CLEAR,
      C_SQ_BAD,
      C_MUL_BUSY,
      C_OVF,
      C_EXP_LAST,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      action_type action;
      cond_type   cond;
      upc_type    target;
   } ctrl_type;

   // Microcode program, one control word per step.
   function automatic ctrl_type ucode(upc_type step);
      ctrl_type cw;
      case (step)
         S_IDLE:   cw = '{A_LOAD,    C_NO_START,  S_IDLE};
         S_PREP:   cw = '{A_PREP,    C_EXP_NEG,   S_FIN};
         S_ZCHK:   cw = '{A_NONE,    C_EXP_ZERO,  S_FIN};
         S_TEST:   cw = '{A_NONE,    C_BIT_CLEAR, S_SQ};
         S_CHKBAD: cw = '{A_SETFAIL, C_SQ_BAD,    S_FIN};
         S_MULA:   cw = '{A_MUL_ACC, C_MUL_BUSY,  S_MULA};
         S_WRA:    cw = '{A_WRACC,   C_OVF,       S_FIN};
         S_SQ:     cw = '{A_SHIFT,   C_EXP_LAST,  S_FIN};
         S_SKIPSQ: cw = '{A_NONE,    C_SQ_BAD,    S_TEST};
         S_MULS:   cw = '{A_MUL_SQ,  C_MUL_BUSY,  S_MULS};
         S_WRS:    cw = '{A_WRSQ,    C_ALWAYS,    S_TEST};
         S_FIN:    cw = '{A_FINISH,  C_OUT_BUSY,  S_FIN};
         S_RET:    cw = '{A_NONE,    C_ALWAYS,    S_IDLE};
         default:  cw = '{A_NONE,    C_ALWAYS,    S_IDLE};
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/checked_integer_power_top.sv =====
// Square-and-multiply over each exponent bit up to the highest set bit. A negative exponent
// goes from the prepare step straight to the finish step, a zero exponent after the zero check.
// Each multiply runs on one shared half-width multiplier (four partial products and a final
// accumulate); one item is worked on at a time, and the next item is accepted once the
// sequencer has passed from the finish step through the return step back to idle.
// Reset is synchronous, active high.
// ----------------------------------------------------------------------------
// Checked integer power
// Square-and-multiply exponentiation with overflow checking, run by a
// microcoded sequencer over a shared multiplier.
// ----------------------------------------------------------------------------
module checked_integer_power_top #(
   parameter int VALUE_BYTES = cip_pkg::VALUE_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: base_value [63:0], exponent_value [127:64]
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [cip_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: base_is_signed [0], exponent_is_signed [1]
   input  logic [cip_pkg::REQ_USER_W-1:0] req_tuser,
   // rsp_tdata: power_value [63:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [cip_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: power_is_signed [0], status [1]
   output logic [cip_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import cip_pkg::*;

   localparam int W  = 8 * VALUE_BYTES;
   localparam int H  = W / 2;
   localparam int PW = 2 * W;
   localparam logic [W-1:0] WTOP = {1'b1, {(W-1){1'b0}}};

   // Sequencer state.
   upc_type         upc_ff, upc_in;
   logic [MC_W-1:0] mc_ff, mc_in;
   ctrl_type        ctrl;
   logic            take;

   // Datapath registers.
   logic [W-1:0]  sq_ff, sq_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  expo_ff, expo_in;
   logic          exp_signed_ff, exp_signed_in;
   logic          base_signed_ff, base_signed_in;
   logic          neg_ff, neg_in;
   logic          sq_bad_ff, sq_bad_in;
   logic          fail_ff, fail_in;
   logic [W-1:0]  pp_ff, pp_in;
   logic [1:0]    sh_ff, sh_in;
   logic [PW-1:0] prod_ff, prod_in;

   // Output register.
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                  rsp_signed_ff, rsp_signed_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic         out_busy;
   logic         prod_ovf;
   logic [W-1:0] mul_x;
   logic [H-1:0] x_half;
   logic [H-1:0] y_half;
   logic         fin_fail;
   logic [W-1:0] acc_neg;

   assign ctrl       = ucode(upc_ff);
   assign req_tready = (upc_ff == S_IDLE);
   assign out_busy   = rsp_tvalid_ff && !rsp_tready;
   assign prod_ovf   = |prod_ff[PW-1:W];

   // Multiplier operands: counter bit 0 picks the half of x, bit 1 the half of y.
   assign mul_x  = (ctrl.action == A_MUL_ACC) ? acc_ff : sq_ff;
   assign x_half = mc_ff[0] ? mul_x[W-1:H] : mul_x[H-1:0];
   assign y_half = mc_ff[1] ? sq_ff[W-1:H] : sq_ff[H-1:0];

   // A negative result above the most negative value does not fit.
   assign fin_fail = fail_ff || (neg_ff && (acc_ff > WTOP));

   // Negated magnitude at the operand width.
   assign acc_neg = W'(0) - acc_ff;

   // Jump condition of the current step.
   always_comb begin
      case (ctrl.cond)
         C_ALWAYS:    take = 1'b1;
         C_NO_START:  take = !req_tvalid;
         C_EXP_NEG:   take = exp_signed_ff && expo_ff[W-1];
         C_EXP_ZERO:  take = (expo_ff == '0);
         C_BIT_CLEAR: take = !expo_ff[0];
         C_SQ_BAD:    take = sq_bad_ff;
         C_MUL_BUSY:  take = (mc_ff != MC_DONE);
         C_OVF:       take = prod_ovf;
         C_EXP_LAST:  take = (expo_ff[W-1:1] == '0);
         C_OUT_BUSY:  take = out_busy;
         default:     take = 1'b0;
      endcase
   end

   // Datapath actions and next step.
   always_comb begin
      upc_in         = take ? ctrl.target : upc_ff + 4'd1;
      mc_in          = '0;
      sq_in          = sq_ff;
      acc_in         = acc_ff;
      expo_in        = expo_ff;
      exp_signed_in  = exp_signed_ff;
      base_signed_in = base_signed_ff;
      neg_in         = neg_ff;
      sq_bad_in      = sq_bad_ff;
      fail_in        = fail_ff;
      pp_in          = pp_ff;
      sh_in          = sh_ff;
      prod_in        = prod_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_value_in   = rsp_value_ff;
      rsp_signed_in  = rsp_signed_ff;
      rsp_status_in  = rsp_status_ff;

      case (ctrl.action)
         A_LOAD: begin
            if (req_tvalid) begin
               sq_in          = req_tdata[W-1:0];
               expo_in        = req_tdata[VALUE_W +: W];
               base_signed_in = req_tuser[0];
               exp_signed_in  = req_tuser[1];
               acc_in         = W'(1);
               neg_in         = 1'b0;
               sq_bad_in      = 1'b0;
               fail_in        = 1'b0;
            end
         end
         A_PREP: begin
            // A negative exponent gives zero; a negative base is made positive.
            if (exp_signed_ff && expo_ff[W-1]) begin
               acc_in = '0;
            end else if (base_signed_ff && sq_ff[W-1]) begin
               sq_in  = W'(0) - sq_ff;
               neg_in = expo_ff[0];
            end
         end
         A_SETFAIL: begin
            fail_in = sq_bad_ff;
         end
         A_MUL_ACC, A_MUL_SQ: begin
            // One partial product per cycle, each accumulated in the following cycle.
            if (mc_ff != MC_DONE) begin
               pp_in = W'(x_half) * W'(y_half);
               sh_in = 2'(mc_ff[0]) + 2'(mc_ff[1]);
               mc_in = mc_ff + MC_W'(1);
            end
            if (mc_ff == '0) begin
               prod_in = '0;
            end else begin
               prod_in = prod_ff + (PW'(pp_ff) << (H * int'(sh_ff)));
            end
         end
         A_WRACC: begin
            acc_in  = prod_ff[W-1:0];
            fail_in = prod_ovf;
         end
         A_SHIFT: begin
            expo_in = expo_ff >> 1;
         end
         A_WRSQ: begin
            sq_in     = prod_ff[W-1:0];
            sq_bad_in = prod_ovf;
         end
         A_FINISH: begin
            if (!out_busy) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = fin_fail;
               rsp_signed_in = !fin_fail && neg_ff;
               if (fin_fail) begin
                  rsp_value_in = '0;
               end else if (neg_ff) begin
                  rsp_value_in = VALUE_W'(acc_neg);
               end else begin
                  rsp_value_in = VALUE_W'(acc_ff);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff        <= S_IDLE;
         mc_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         upc_ff        <= upc_in;
         mc_ff         <= mc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sq_ff          <= sq_in;
      acc_ff         <= acc_in;
      expo_ff        <= expo_in;
      exp_signed_ff  <= exp_signed_in;
      base_signed_ff <= base_signed_in;
      neg_ff         <= neg_in;
      sq_bad_ff      <= sq_bad_in;
      fail_ff        <= fail_in;
      pp_ff          <= pp_in;
      sh_ff          <= sh_in;
      prod_ff        <= prod_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_signed_ff  <= rsp_signed_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_signed_ff};

`ifndef SYNTHESIS
   // The partial product counter only runs inside a multiply step.
   a_mc_in_mul: assert property (@(posedge clock) disable iff (reset)
      (mc_ff != '0) |-> (upc_ff == S_MULA || upc_ff == S_MULS))
      else $error("multiply counter active outside a multiply step");

   // A new result is only loaded by the finish step.
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(upc_ff) == S_FIN))
      else $error("result loaded outside the finish step");

   // An overflow result never carries a negative sign.
   a_fail_unsigned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !(rsp_status_ff && rsp_signed_ff))
      else $error("overflow result marked as negative");

   // The step counter stays within the program.
   a_upc_range: assert property (@(posedge clock) disable iff (reset)
      upc_ff <= S_RET)
      else $error("step counter beyond program end");
`endif

endmodule
